// ----- rtl/core/input_change_recorder_player_unit_assert.svh -----
// Assertion macros shared by the recorder/player RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef INPUT_CHANGE_RECORDER_PLAYER_UNIT_ASSERT_SVH
`define INPUT_CHANGE_RECORDER_PLAYER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ICRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ICRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ICRP_ASSERT(lbl, prop, msg)
`define ICRP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/icrp_pkg.sv -----
// Shared constants and types of the input change recorder/player.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icrp_pkg;

  // Event store geometry
  localparam int EVENT_DEPTH = 1024;
  localparam int STAMP_BITS  = 32;
  localparam int ADDR_W      = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int IDX_W       = $clog2(EVENT_DEPTH + 1);

  // Mode register codes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_RECORD   = 2'd1;
  localparam logic [1:0] MODE_PLAYBACK = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // Key substituted while fire is pressed in playback ('Q')
  localparam logic [15:0] FORCED_KEY = 16'h0051;

  typedef struct packed {
    logic [7:0] joy2_buttons;
    logic [7:0] joy2_position;
    logic [7:0] joy1_buttons;
    logic [7:0] joy1_position;
  } joy_t;

  typedef struct packed {
    logic [15:0] key_code;
    joy_t        joy;
  } sample_t;

  // One stored event: sample plus frame stamp
  typedef struct packed {
    sample_t                 sample;
    logic [STAMP_BITS-1:0]   stamp;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

  typedef struct packed {
    sample_t    sample;
    logic       overrun;
    logic [1:0] mode;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/icrp_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module icrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/icrp_engine.sv -----
// Record/playback engine: control state plus the event store read-modify loop.
// Depends on icrp_pkg, icrp_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "input_change_recorder_player_unit_assert.svh"

module icrp_engine
  import icrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire sample_t    live_i,
  input  wire logic       fire_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_mode_i,
  output result_t         res_o
);

  logic [1:0]            mode_q, mode_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [STAMP_BITS-1:0] frame_q, frame_d;
  sample_t               last_q, last_d;
  joy_t                  held_q, held_d;

  logic                  wr_en;
  event_t                wr_event;
  event_t                rd_event;
  logic                  room;
  logic                  changed;
  logic [IDX_W-1:0]      idx_inc;

  assign room    = (idx_q < IDX_W'(EVENT_DEPTH));
  assign changed = (live_i != last_q);
  assign idx_inc = idx_q + 1'b1;

  assign wr_event.sample = live_i;
  assign wr_event.stamp  = frame_q;

  // Event store; read address runs on the next index so the entry is ready
  icrp_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (EVENT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q[ADDR_W-1:0]),
    .wdata_i (wr_event),
    .raddr_i (idx_d[ADDR_W-1:0]),
    .rdata_o (rd_event)
  );

  // Next state and result of the current request
  always_comb begin
    mode_d  = mode_q;
    idx_d   = idx_q;
    frame_d = frame_q;
    last_d  = last_q;
    held_d  = held_q;
    wr_en   = 1'b0;
    res_o.sample  = live_i;
    res_o.overrun = 1'b0;
    res_o.mode    = mode_q;
    if (cfg_we_i) begin
      mode_d  = (cfg_mode_i == MODE_UNUSED) ? MODE_IDLE : cfg_mode_i;
      idx_d   = '0;
      frame_d = '0;
      last_d  = '1;
      held_d  = '0;
    end else if (acc_i) begin
      frame_d = frame_q + 1'b1;
      unique case (mode_q)
        MODE_RECORD: begin
          if (changed) begin
            if (room) begin
              wr_en  = 1'b1;
              last_d = live_i;
              idx_d  = idx_inc;
            end else begin
              res_o.overrun = 1'b1;
            end
          end
        end
        MODE_PLAYBACK: begin
          if (fire_i) begin
            res_o.sample.key_code = FORCED_KEY;
          end
          if (room) begin
            if (rd_event.stamp == frame_q) begin
              held_d                = rd_event.sample.joy;
              res_o.sample.key_code = rd_event.sample.key_code;
              idx_d                 = idx_inc;
            end
            res_o.sample.joy = held_d;
          end else begin
            res_o.overrun = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      idx_q   <= '0;
      frame_q <= '0;
      last_q  <= '1;
      held_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      idx_q   <= idx_d;
      frame_q <= frame_d;
      last_q  <= last_d;
      held_q  <= held_d;
    end
  end

  `ICRP_ASSERT(a_idx_bound, idx_q <= IDX_W'(EVENT_DEPTH), "entry index past depth")
  `ICRP_ASSERT(a_wr_record, wr_en |-> (acc_i && mode_q == MODE_RECORD && room), "stray store write")
  `ICRP_ASSERT(a_cfg_clear, cfg_we_i |=> (idx_q == '0 && frame_q == '0), "config did not reinit")
  `ICRP_ASSERT(a_frame_step, (acc_i && !cfg_we_i) |=> frame_q == $past(frame_q) + 1'b1, "frame slip")

endmodule

`default_nettype wire

// ----- rtl/core/icrp_outq.sv -----
// Two-entry result queue that decouples the output stall from the input side.
// Depends on icrp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "input_change_recorder_player_unit_assert.svh"

module icrp_outq
  import icrp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    stall_i,
  output result_t      head_o
);

  logic [1:0] count_q, count_d;
  result_t    head_q, head_d;
  result_t    spare_q, spare_d;
  logic       pop;

  assign pop     = (count_q != 2'd0) && !stall_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = head_q;

  // Advance the queue on push and pop
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    spare_d = spare_q;
    if (push_i && pop) begin
      if (count_q == 2'd2) begin
        head_d  = spare_q;
        spare_d = push_data_i;
      end else begin
        head_d = push_data_i;
      end
    end else if (pop) begin
      head_d  = spare_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        head_d = push_data_i;
      end else begin
        spare_d = push_data_i;
      end
      count_d = count_q + 2'd1;
    end
  end

  // Hold occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  `ICRP_ASSERT(a_count_max, count_q != 2'd3, "queue count out of range")
  `ICRP_ASSERT(a_no_ovf, push_i |-> !full_o, "push into full queue")

endmodule

`default_nettype wire

// ----- rtl/core/input_change_recorder_player_unit.sv -----
// Top level of the input change recorder/player.
// Depends on icrp_pkg, icrp_engine, icrp_outq and icrp_ram.
`timescale 1ns / 1ps
`default_nettype none

// Takes one frame tick per request and returns one result per tick. A tick is
// taken every clock cycle while the queue has room: the event store is a
// single synchronous RAM whose read address tracks the next entry index, so
// the entry a playback tick compares against is always already read. Results
// go through a two-entry queue; the input stalls only when both entries wait
// on the output side, and the input stall comes straight from the queue
// occupancy register. Mode writes are taken in any cycle in which no tick
// request is offered (cfg_ready_o is low while in_valid_i is high), so a tick
// and a mode write never share a cycle. A mode write reinitializes index,
// frame count, last and held values; the event store keeps its contents and
// needs no clearing after reset. Playback must follow a recording that wrote
// the entries it reads.
module input_change_recorder_player_unit
  import icrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Mode register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,
  // Tick request
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  joy1_position_i,
  input  wire logic [7:0]  joy1_buttons_i,
  input  wire logic [7:0]  joy2_position_i,
  input  wire logic [7:0]  joy2_buttons_i,
  input  wire logic [15:0] key_code_i,
  input  wire logic        fire_abort_i,
  // Result request
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_joy1_position_o,
  output logic [7:0]       out_joy1_buttons_o,
  output logic [7:0]       out_joy2_position_o,
  output logic [7:0]       out_joy2_buttons_o,
  output logic [15:0]      out_key_code_o,
  output logic             overrun_o,
  output logic [1:0]       current_mode_o
);

  sample_t live;
  result_t res;
  result_t head;
  logic    full;
  logic    acc;
  logic    cfg_we;

  // Hold mode writes off while a tick request is offered
  assign cfg_ready_o = !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = full;
  assign acc         = in_valid_i && !full;

  assign live.joy.joy1_position = joy1_position_i;
  assign live.joy.joy1_buttons  = joy1_buttons_i;
  assign live.joy.joy2_position = joy2_position_i;
  assign live.joy.joy2_buttons  = joy2_buttons_i;
  assign live.key_code          = key_code_i;

  icrp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .live_i     (live),
    .fire_i     (fire_abort_i),
    .cfg_we_i   (cfg_we),
    .cfg_mode_i (cfg_data_i),
    .res_o      (res)
  );

  icrp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .push_data_i (res),
    .full_o      (full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .head_o      (head)
  );

  // Drive result fields from the queue head
  assign out_joy1_position_o = head.sample.joy.joy1_position;
  assign out_joy1_buttons_o  = head.sample.joy.joy1_buttons;
  assign out_joy2_position_o = head.sample.joy.joy2_position;
  assign out_joy2_buttons_o  = head.sample.joy.joy2_buttons;
  assign out_key_code_o      = head.sample.key_code;
  assign overrun_o           = head.overrun;
  assign current_mode_o      = head.mode;

endmodule

`default_nettype wire

// ----- sim/tb_input_change_recorder_player_unit.sv -----
// Self-checking testbench of input_change_recorder_player_unit.
// Depends on icrp_pkg and the recorder/player RTL; needs no other files.
`timescale 1ns / 1ps

module tb_input_change_recorder_player_unit;
  import icrp_pkg::*;

  localparam int LONG_HOLD    = 40;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    sample_t sample;
    logic    fire;
  } tick_t;

  // Tracks recorder/player state and the results each accepted tick owes
  class replay_scoreboard;
    result_t                 expected_results[$];
    int unsigned             mismatches;
    int unsigned             filled;
    logic [1:0]              mode;
    joy_t                    last_joy;
    joy_t                    held_joy;
    logic [15:0]             last_key;
    int unsigned             entry_index;
    logic [STAMP_BITS-1:0]   frame_count;
    sample_t                 event_samples [EVENT_DEPTH];
    logic [STAMP_BITS-1:0]   event_stamps [EVENT_DEPTH];

    function new();
      mode       = MODE_IDLE;
      filled     = 0;
      mismatches = 0;
      restart();
    endfunction

    // Clear index, frame and last/held values; keep the event store
    function void restart();
      entry_index = 0;
      frame_count = '0;
      last_joy    = '1;
      last_key    = '1;
      held_joy    = '0;
    endfunction

    function void write_mode(logic [1:0] value);
      mode = (value == MODE_UNUSED) ? MODE_IDLE : value;
      restart();
    endfunction

    // Work out the result of one accepted tick and queue it
    function void note_tick(sample_t live, logic fire);
      result_t want;
      sample_t shown;
      shown        = live;
      want.overrun = 1'b0;
      if (mode == MODE_RECORD) begin
        if (live.joy != last_joy || live.key_code != last_key) begin
          if (entry_index < EVENT_DEPTH) begin
            event_samples[entry_index] = live;
            event_stamps[entry_index]  = frame_count;
            last_joy = live.joy;
            last_key = live.key_code;
            entry_index++;
            if (entry_index > filled) filled = entry_index;
          end else begin
            want.overrun = 1'b1;
          end
        end
      end else if (mode == MODE_PLAYBACK) begin
        if (fire) shown.key_code = FORCED_KEY;
        if (entry_index < EVENT_DEPTH) begin
          if (event_stamps[entry_index] == frame_count) begin
            held_joy       = event_samples[entry_index].joy;
            shown.key_code = event_samples[entry_index].key_code;
            entry_index++;
          end
          shown.joy = held_joy;
        end else begin
          want.overrun = 1'b1;
        end
      end
      frame_count++;
      want.sample = shown;
      want.mode   = mode;
      expected_results.push_back(want);
    endfunction

    task report(string msg);
      // Keep the log short; every mismatch still counts
      if (mismatches < MAX_PRINTS) $display("ERROR: %s", msg);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result with no tick outstanding");
      end else begin
        want = expected_results.pop_front();
        if (got.sample.joy.joy1_position !== want.sample.joy.joy1_position)
          report($sformatf("joy1_position got %h want %h",
                           got.sample.joy.joy1_position, want.sample.joy.joy1_position));
        if (got.sample.joy.joy1_buttons !== want.sample.joy.joy1_buttons)
          report($sformatf("joy1_buttons got %h want %h",
                           got.sample.joy.joy1_buttons, want.sample.joy.joy1_buttons));
        if (got.sample.joy.joy2_position !== want.sample.joy.joy2_position)
          report($sformatf("joy2_position got %h want %h",
                           got.sample.joy.joy2_position, want.sample.joy.joy2_position));
        if (got.sample.joy.joy2_buttons !== want.sample.joy.joy2_buttons)
          report($sformatf("joy2_buttons got %h want %h",
                           got.sample.joy.joy2_buttons, want.sample.joy.joy2_buttons));
        if (got.sample.key_code !== want.sample.key_code)
          report($sformatf("key_code got %h want %h",
                           got.sample.key_code, want.sample.key_code));
        if (got.overrun !== want.overrun)
          report($sformatf("overrun got %b want %b", got.overrun, want.overrun));
        if (got.mode !== want.mode)
          report($sformatf("current_mode got %0d want %0d", got.mode, want.mode));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  joy1_position_i;
  logic [7:0]  joy1_buttons_i;
  logic [7:0]  joy2_position_i;
  logic [7:0]  joy2_buttons_i;
  logic [15:0] key_code_i;
  logic        fire_abort_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_joy1_position_o;
  logic [7:0]  out_joy1_buttons_o;
  logic [7:0]  out_joy2_position_o;
  logic [7:0]  out_joy2_buttons_o;
  logic [15:0] out_key_code_o;
  logic        overrun_o;
  logic [1:0]  current_mode_o;

  replay_scoreboard sb = new();

  int gap_pct   = 25;
  int stall_pct = 20;
  bit hold_req  = 1'b0;
  int unsigned cycle_count = 0;

  input_change_recorder_player_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .joy1_position_i    (joy1_position_i),
    .joy1_buttons_i     (joy1_buttons_i),
    .joy2_position_i    (joy2_position_i),
    .joy2_buttons_i     (joy2_buttons_i),
    .key_code_i         (key_code_i),
    .fire_abort_i       (fire_abort_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_joy1_position_o(out_joy1_position_o),
    .out_joy1_buttons_o (out_joy1_buttons_o),
    .out_joy2_position_o(out_joy2_position_o),
    .out_joy2_buttons_o (out_joy2_buttons_o),
    .out_key_code_o     (out_key_code_o),
    .overrun_o          (overrun_o),
    .current_mode_o     (current_mode_o)
  );

  always #4 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Observe mode writes, tick requests and result requests in one place
  always @(posedge clk_i) begin : observe
    sample_t live;
    result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_mode(cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        live.joy.joy1_position = joy1_position_i;
        live.joy.joy1_buttons  = joy1_buttons_i;
        live.joy.joy2_position = joy2_position_i;
        live.joy.joy2_buttons  = joy2_buttons_i;
        live.key_code          = key_code_i;
        sb.note_tick(live, fire_abort_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got.sample.joy.joy1_position = out_joy1_position_o;
        got.sample.joy.joy1_buttons  = out_joy1_buttons_o;
        got.sample.joy.joy2_position = out_joy2_position_o;
        got.sample.joy.joy2_buttons  = out_joy2_buttons_o;
        got.sample.key_code          = out_key_code_o;
        got.overrun                  = overrun_o;
        got.mode                     = current_mode_o;
        sb.check_result(got);
      end
    end
  end

  // Stall the result side in short bursts, or for one long hold on demand
  initial begin : receiver
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic tick_t make_tick(logic [7:0] p1, logic [7:0] b1, logic [7:0] p2,
                                      logic [7:0] b2, logic [15:0] key, logic fire);
    tick_t t;
    t.sample.joy.joy1_position = p1;
    t.sample.joy.joy1_buttons  = b1;
    t.sample.joy.joy2_position = p2;
    t.sample.joy.joy2_buttons  = b2;
    t.sample.key_code          = key;
    t.fire                     = fire;
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.sample.joy      = $urandom();
    t.sample.key_code = 16'($urandom_range(0, 16'hffff));
    t.fire            = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Offer one tick request, hold it until taken, then maybe idle
  task automatic send_tick(tick_t t);
    in_valid_i      <= 1'b1;
    joy1_position_i <= t.sample.joy.joy1_position;
    joy1_buttons_i  <= t.sample.joy.joy1_buttons;
    joy2_position_i <= t.sample.joy.joy2_position;
    joy2_buttons_i  <= t.sample.joy.joy2_buttons;
    key_code_i      <= t.sample.key_code;
    fire_abort_i    <= t.fire;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
  endtask

  task automatic write_mode(logic [1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    tick_t       prev;
    tick_t       t;
    int unsigned record_ticks;
    int unsigned spill;
    int          i;

    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= MODE_IDLE;
    in_valid_i      <= 1'b0;
    joy1_position_i <= '0;
    joy1_buttons_i  <= '0;
    joy2_position_i <= '0;
    joy2_buttons_i  <= '0;
    key_code_i      <= '0;
    fire_abort_i    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle after reset: extremes pass straight through, fire has no effect
    send_tick(make_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
    send_tick(make_tick(8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b1));
    send_tick(make_tick(8'haa, 8'h55, 8'h55, 8'haa, 16'h5555, 1'b1));
    finish_phase();

    // Unused mode code behaves as idle
    write_mode(MODE_UNUSED);
    send_tick(rand_tick());
    send_tick(make_tick(8'h55, 8'haa, 8'haa, 8'h55, 16'haaaa, 1'b1));
    finish_phase();

    // Record: all ones matches the cleared last values, so it is not stored
    write_mode(MODE_RECORD);
    send_tick(make_tick(8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b0));
    send_tick(make_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1));
    send_tick(make_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
    send_tick(make_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h0001, 1'b0));
    prev = make_tick(8'h00, 8'h00, 8'h00, 8'h80, 16'h0001, 1'b1);
    send_tick(prev);
    record_ticks = 5;

    // Fill the whole event store, then keep going to drop changes on overrun
    spill = 0;
    while (sb.filled < EVENT_DEPTH || spill < 24) begin
      t = rand_tick();
      if ($urandom_range(0, 23) == 0) t.sample = prev.sample;
      send_tick(t);
      prev = t;
      record_ticks++;
      if (sb.filled == EVENT_DEPTH) spill++;
      // Pause the sender once mid-recording until all results are back
      if (record_ticks == 400) finish_phase();
    end
    finish_phase();

    // Replay the start of the recording
    write_mode(MODE_PLAYBACK);
    for (i = 0; i < 140; i++) begin
      if (i == 40) begin
        hold_req = 1'b1;
        gap_pct  = 0;
      end
      if (i == 100) gap_pct = 25;
      send_tick(rand_tick());
    end
    finish_phase();

    write_mode(MODE_IDLE);
    for (i = 0; i < 20; i++) send_tick(rand_tick());
    finish_phase();

    write_mode(MODE_UNUSED);
    for (i = 0; i < 10; i++) send_tick(rand_tick());
    finish_phase();

    // Short re-recording over the start of the store
    write_mode(MODE_RECORD);
    for (i = 0; i < 40; i++) begin
      t = rand_tick();
      if ($urandom_range(0, 3) == 0) t.sample = prev.sample;
      send_tick(t);
      prev = t;
    end
    finish_phase();

    // Last stretch runs without any idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    write_mode(MODE_PLAYBACK);
    for (i = 0; i < 50; i++) send_tick(rand_tick());
    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.expected_results.size() != 0) sb.report("results still owed at end of run");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
